// ===== src/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

  localparam int PG_SHIFT = 12;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NOT_BSY = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  order;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
  } rsp_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_INIT_TAIL,
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_TAKE_RD,
    S_UNL_PN,
    S_UNL_WR,
    S_SPLIT,
    S_SPLIT_WR,
    S_MARK,
    S_FREE_RD,
    S_FREE_CHK,
    S_BUD_RD,
    S_BUD_CHK,
    S_PUT_HEAD,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic init_step;
    logic load_req;
    logic search_step;
    logic take;
    logic rd_b;
    logic unlink;
    logic split;
    logic mark_busy;
    logic free_clr;
    logic bud_rd;
    logic merge;
    logic put_head;
    logic respond;
    logic [1:0] code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;
    logic ord_bad;
    logic is_free;
    logic found;
    logic search_end;
    logic split_more;
    logic addr_bad;
    logic b_busy;
    logic ord_match;
    logic bud_ok;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/buddy_page_allocator_top.sv =====
// channel   | ports                          | handshake
// config    | heap_base_we, heap_base        | write at edge with we high
// request   | start, busy, req               | start && !busy
// result    | done, rsp                      | done for one cycle
// After reset an init pass visits every page in turn, clearing and chaining
// the link memories; busy stays high throughout.
// An allocation searches one order at a time, unlinks the block and splits it;
// a free merges the block with free buddies level by level, then relinks it.
// The result cannot be stalled; next request is taken after done.
`default_nettype none
module buddy_page_allocator_top #(
  parameter int PAGE_COUNT  = 4096,
  parameter int ORDER_COUNT = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          heap_base_we,
  input  wire logic [31:0]   heap_base,
  input  wire logic          start,
  output logic               busy,
  input  wire bpa_pkg::req_t req,
  output logic               done,
  output bpa_pkg::rsp_t      rsp
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bpa_datapath #(
    .PAGE_COUNT  (PAGE_COUNT),
    .ORDER_COUNT (ORDER_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (heap_base_we),
    .cfg_data   (heap_base),
    .req        (req),
    .cmd        (cmd),
    .sts        (sts),
    .resp_valid (done),
    .resp       (rsp)
  );

endmodule
`default_nettype wire

// ===== src/bpa_ctrl.sv =====
`default_nettype none
module bpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t      cmd
);

  bpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      bpa_pkg::S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_req = 1'b1;
          state_next = bpa_pkg::S_CHECK;
        end
      end
      bpa_pkg::S_CHECK: begin
        if (sts.ord_bad) begin
          cmd.respond = 1'b1;
          cmd.code = bpa_pkg::ST_BAD;
          state_next = bpa_pkg::S_DONE;
        end else if (sts.is_free) begin
          if (sts.addr_bad) begin
            cmd.respond = 1'b1;
            cmd.code = bpa_pkg::ST_BAD;
            state_next = bpa_pkg::S_DONE;
          end else begin
            cmd.rd_b = 1'b1;
            state_next = bpa_pkg::S_FREE_RD;
          end
        end else begin
          state_next = bpa_pkg::S_SEARCH;
        end
      end
      bpa_pkg::S_SEARCH: begin
        if (sts.found) begin
          cmd.take = 1'b1;
          state_next = bpa_pkg::S_TAKE_RD;
        end else if (sts.search_end) begin
          cmd.respond = 1'b1;
          cmd.code = bpa_pkg::ST_NO_FREE;
          state_next = bpa_pkg::S_DONE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      bpa_pkg::S_TAKE_RD: state_next = bpa_pkg::S_UNL_PN;
      bpa_pkg::S_UNL_PN: begin
        cmd.unlink = 1'b1;
        state_next = bpa_pkg::S_UNL_WR;
      end
      bpa_pkg::S_UNL_WR: begin
        if (sts.is_free) state_next = bpa_pkg::S_BUD_RD;
        else state_next = bpa_pkg::S_SPLIT;
      end
      bpa_pkg::S_SPLIT: begin
        if (sts.split_more) begin
          cmd.split = 1'b1;
          state_next = bpa_pkg::S_SPLIT_WR;
        end else begin
          state_next = bpa_pkg::S_MARK;
        end
      end
      bpa_pkg::S_SPLIT_WR: state_next = bpa_pkg::S_SPLIT;
      bpa_pkg::S_MARK: begin
        cmd.mark_busy = 1'b1;
        cmd.respond = 1'b1;
        cmd.code = bpa_pkg::ST_OK;
        state_next = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_FREE_RD: state_next = bpa_pkg::S_FREE_CHK;
      bpa_pkg::S_FREE_CHK: begin
        if (!sts.b_busy) begin
          cmd.respond = 1'b1;
          cmd.code = bpa_pkg::ST_NOT_BSY;
          state_next = bpa_pkg::S_DONE;
        end else if (!sts.ord_match) begin
          cmd.respond = 1'b1;
          cmd.code = bpa_pkg::ST_BAD;
          state_next = bpa_pkg::S_DONE;
        end else begin
          cmd.free_clr = 1'b1;
          state_next = bpa_pkg::S_BUD_RD;
        end
      end
      bpa_pkg::S_BUD_RD: begin
        cmd.bud_rd = 1'b1;
        state_next = bpa_pkg::S_BUD_CHK;
      end
      bpa_pkg::S_BUD_CHK: begin
        if (sts.bud_ok) begin
          cmd.merge = 1'b1;
          state_next = bpa_pkg::S_UNL_PN;
        end else begin
          state_next = bpa_pkg::S_PUT_HEAD;
        end
      end
      bpa_pkg::S_PUT_HEAD: begin
        cmd.put_head = 1'b1;
        cmd.respond = 1'b1;
        cmd.code = bpa_pkg::ST_OK;
        state_next = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_DONE: state_next = bpa_pkg::S_IDLE;
      default: state_next = bpa_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::S_IDLE) |-> !busy) else $error("busy in idle");
  a_resp_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |-> busy) else $error("response while idle");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> (state == bpa_pkg::S_DONE)) else $error("no done");
`endif

endmodule
`default_nettype wire

// ===== src/bpa_datapath.sv =====
`default_nettype none
module bpa_datapath #(
  parameter int PAGE_COUNT  = 4096,
  parameter int ORDER_COUNT = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_data,
  input  wire bpa_pkg::req_t req,
  input  wire bpa_pkg::cmd_t cmd,
  output bpa_pkg::sts_t      sts,
  output logic               resp_valid,
  output bpa_pkg::rsp_t      resp
);

  localparam int PW    = $clog2(PAGE_COUNT);
  localparam int LW    = PW + 1;
  localparam int OW    = $clog2(ORDER_COUNT);
  localparam int TOP   = ORDER_COUNT - 1;
  localparam int TOPSZ = 1 << TOP;
  localparam int FULL  = (PAGE_COUNT / TOPSZ) * TOPSZ;
  localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);

  logic [LW-1:0] nxt_mem [PAGE_COUNT];
  logic [LW-1:0] prv_mem [PAGE_COUNT];
  logic [3:0]    ord_mem [PAGE_COUNT];
  logic          fh_mem  [PAGE_COUNT];
  logic          bsy_mem [PAGE_COUNT];
  logic [LW-1:0] first [ORDER_COUNT];
  logic [LW-1:0] last  [ORDER_COUNT];

  logic [31:0] heap_base;
  logic        kind;
  logic [3:0]  rord;
  logic [31:0] raddr;
  logic [OW-1:0] j;
  logic [PW-1:0] b;
  logic [PW-1:0] bud;
  logic [LW-1:0] init_pg;
  logic [OW-1:0] init_k;
  logic          init_head;
  logic [LW-1:0] rd_next, rd_prev;
  logic [3:0]    rd_ord;
  logic          rd_fh, rd_bsy;
  logic [PW-1:0] ua;
  logic [OW-1:0] uk;
  logic          u_is_bud;

  // main write port
  logic          we;
  logic [PW-1:0] wa;
  logic [LW-1:0] wn, wp;
  logic [3:0]    wo;
  logic          wfh, wbsy;
  logic          wn_en, wp_en, wo_en, wfh_en, wbsy_en;
  // second link write port for neighbour pointer fix-up
  logic          we2;
  logic [PW-1:0] wa2;
  logic          we2_next_field;
  logic [LW-1:0] wd2;

  logic [31:0] off;
  logic [PW-1:0] off_pg;
  logic [LW:0]   end_pg;
  logic [LW:0]   bud_end;
  logic [PW-1:0] rd_addr;

  assign off    = raddr - heap_base;
  assign off_pg = PW'(off >> bpa_pkg::PG_SHIFT);
  assign end_pg = (LW+1)'(off >> bpa_pkg::PG_SHIFT);

  // init pass visits every page; block heads are chained, the rest cleared
  assign init_head = (init_pg >= LW'(FULL)) || ((init_pg & LW'(TOPSZ - 1)) == '0);
  assign init_k    = (init_pg >= LW'(FULL)) ? '0 : OW'(TOP);

  always_comb begin
    logic [31:0] sz;
    sz = 32'd1 << rord;
    sts = '0;
    sts.init_last  = init_pg == LW'(PAGE_COUNT - 1);
    sts.ord_bad    = {1'b0, rord} >= 5'(ORDER_COUNT);
    sts.is_free    = kind == bpa_pkg::KIND_FREE;
    sts.found      = first[j] != NIL;
    sts.search_end = j == OW'(TOP);
    sts.split_more = uk > OW'(rord);
    sts.addr_bad   = (off[bpa_pkg::PG_SHIFT-1:0] != '0)
                     || ((off >> bpa_pkg::PG_SHIFT) >= 32'(PAGE_COUNT))
                     || ((32'(off_pg) & (sz - 32'd1)) != '0)
                     || ({1'b0, end_pg} + 33'(sz) > 33'(PAGE_COUNT));
    sts.b_busy     = rd_bsy;
    sts.ord_match  = rd_ord == rord;
    sts.bud_ok     = (uk < OW'(TOP)) && (bud_end <= (LW+1)'(PAGE_COUNT))
                     && rd_fh && !rd_bsy && (rd_ord == 4'(uk));
  end

  assign bud_end = (LW+1)'(b ^ (PW'(1) << uk)) + ((LW+1)'(1) << uk);

  // read address
  always_comb begin
    rd_addr = b;
    if (cmd.bud_rd) rd_addr = b ^ (PW'(1) << uk);
    if (cmd.merge) rd_addr = bud;
    if (cmd.take) rd_addr = first[j][PW-1:0];
  end

  always_ff @(posedge clk) begin
    rd_next <= nxt_mem[rd_addr];
    rd_prev <= prv_mem[rd_addr];
    rd_ord  <= ord_mem[rd_addr];
    rd_fh   <= fh_mem[rd_addr];
    rd_bsy  <= bsy_mem[rd_addr];
  end

  always_comb begin
    we = 1'b0; wa = b; wn = NIL; wp = NIL; wo = '0; wfh = 1'b0; wbsy = 1'b0;
    wn_en = 1'b0; wp_en = 1'b0; wo_en = 1'b0; wfh_en = 1'b0; wbsy_en = 1'b0;
    we2 = 1'b0; wa2 = '0; we2_next_field = 1'b0; wd2 = NIL;
    if (cmd.init_step) begin
      we = 1'b1; wa = init_pg[PW-1:0];
      wn = NIL; wp = init_head ? last[init_k] : NIL;
      wo = init_head ? 4'(init_k) : 4'd0; wfh = init_head; wbsy = 1'b0;
      wn_en = 1'b1; wp_en = 1'b1; wo_en = 1'b1; wfh_en = 1'b1; wbsy_en = 1'b1;
      if (init_head && last[init_k] != NIL) begin
        we2 = 1'b1; wa2 = last[init_k][PW-1:0]; we2_next_field = 1'b1;
        wd2 = init_pg;
      end
    end else if (cmd.unlink) begin
      we = 1'b1; wa = ua; wn = NIL; wp = NIL; wfh = 1'b0;
      wn_en = 1'b1; wp_en = 1'b1; wfh_en = 1'b1;
      if (rd_prev != NIL) begin
        we2 = 1'b1; wa2 = rd_prev[PW-1:0]; we2_next_field = 1'b1; wd2 = rd_next;
      end
    end else if (cmd.split) begin
      we = 1'b1; wa = b; wn = NIL; wp = last[uk - 1'b1]; wfh = 1'b1;
      wo = 4'(uk - 1'b1);
      wn_en = 1'b1; wp_en = 1'b1; wfh_en = 1'b1; wo_en = 1'b1;
      if (last[uk - 1'b1] != NIL) begin
        we2 = 1'b1; wa2 = last[uk - 1'b1][PW-1:0]; we2_next_field = 1'b1;
        wd2 = LW'(b);
      end
    end else if (cmd.mark_busy) begin
      we = 1'b1; wa = b; wbsy = 1'b1; wo = rord; wbsy_en = 1'b1; wo_en = 1'b1;
    end else if (cmd.free_clr) begin
      we = 1'b1; wa = b; wbsy = 1'b0; wbsy_en = 1'b1;
    end else if (cmd.put_head) begin
      we = 1'b1; wa = b; wp = NIL; wn = first[uk]; wfh = 1'b1; wo = 4'(uk);
      wn_en = 1'b1; wp_en = 1'b1; wfh_en = 1'b1; wo_en = 1'b1;
      if (first[uk] != NIL) begin
        we2 = 1'b1; wa2 = first[uk][PW-1:0]; we2_next_field = 1'b0;
        wd2 = LW'(b);
      end
    end
  end

  // unlink's next-side fix-up happens in the extra cycle after the main write
  logic          fix_pend;
  logic [PW-1:0] fix_a;
  logic [LW-1:0] fix_d;

  always_ff @(posedge clk) begin
    if (we) begin
      if (wn_en)   nxt_mem[wa] <= wn;
      if (wp_en)   prv_mem[wa] <= wp;
      if (wo_en)   ord_mem[wa] <= wo;
      if (wfh_en)  fh_mem[wa]  <= wfh;
      if (wbsy_en) bsy_mem[wa] <= wbsy;
    end
    if (we2 && we2_next_field) nxt_mem[wa2] <= wd2;
    if (fix_pend) prv_mem[fix_a] <= fix_d;
    if (we2 && !we2_next_field) prv_mem[wa2] <= wd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_pend <= 1'b0;
    end else begin
      fix_pend <= cmd.unlink && (rd_next != NIL);
    end
    fix_a <= rd_next[PW-1:0];
    fix_d <= rd_prev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      init_pg    <= '0;
      resp_valid <= 1'b0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        first[i] <= NIL;
        last[i]  <= NIL;
      end
    end else begin
      resp_valid <= cmd.respond;
      if (cfg_we) heap_base <= cfg_data;
      if (cmd.init_step) begin
        if (init_head) begin
          if (last[init_k] == NIL) first[init_k] <= init_pg;
          last[init_k] <= init_pg;
        end
        init_pg <= init_pg + 1'b1;
      end
      if (cmd.unlink) begin
        if (rd_prev == NIL) first[uk] <= rd_next;
        if (rd_next == NIL) last[uk]  <= rd_prev;
      end
      if (cmd.split) begin
        if (last[uk - 1'b1] == NIL) first[uk - 1'b1] <= LW'(b);
        last[uk - 1'b1] <= LW'(b);
      end
      if (cmd.put_head) begin
        if (first[uk] == NIL) last[uk] <= LW'(b);
        first[uk] <= LW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind  <= req.kind;
      rord  <= req.order;
      raddr <= req.address;
      j     <= OW'(req.order);
    end
    if (cmd.search_step) j <= j + 1'b1;
    if (cmd.take) begin
      b  <= first[j][PW-1:0];
      ua <= first[j][PW-1:0];
      uk <= j;
      u_is_bud <= 1'b0;
    end
    if (cmd.rd_b) begin
      b  <= off_pg;
      uk <= OW'(rord);
    end
    if (cmd.bud_rd) bud <= b ^ (PW'(1) << uk);
    if (cmd.merge) begin
      ua <= bud;
      u_is_bud <= 1'b1;
      if (bud < b) b <= bud;
    end
    if (cmd.unlink && u_is_bud) begin
      uk <= uk + 1'b1;
    end
    if (cmd.split) begin
      b  <= b + (PW'(1) << (uk - 1'b1));
      uk <= uk - 1'b1;
    end
    if (cmd.respond) begin
      resp.status <= cmd.code;
      resp.block_address <= (cmd.code == bpa_pkg::ST_OK && kind == bpa_pkg::KIND_ALLOC)
        ? heap_base + (32'(b) << bpa_pkg::PG_SHIFT) : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_resp_one: assert property (@(posedge clk) disable iff (rst)
    resp_valid |=> !resp_valid) else $error("double response");
  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && kind == bpa_pkg::KIND_FREE) |-> (resp.block_address == '0))
    else $error("free addr");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && resp.status != bpa_pkg::ST_OK) |-> (resp.block_address == '0))
    else $error("error addr");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/buddy_page_allocator_top_tb.sv =====
`default_nettype none
module buddy_page_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES = 4096;
  localparam int ORDERS = 9;
  localparam int TOP = ORDERS - 1;
  localparam int NONE = PAGES;
  localparam int ITEMS = 1250;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic heap_base_we = 1'b0;
  logic [31:0] heap_base = '0;
  logic start = 1'b0;
  logic busy;
  bpa_pkg::req_t req = '0;
  logic done;
  bpa_pkg::rsp_t rsp;

  buddy_page_allocator_top u_top (
    .clk(clk), .rst(rst), .heap_base_we(heap_base_we), .heap_base(heap_base),
    .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // allocator state mirror
  int unsigned nxt [PAGES];
  int unsigned prv [PAGES];
  int unsigned blk_ord [PAGES];
  bit on_list [PAGES];
  bit in_use [PAGES];
  int unsigned first_blk [ORDERS];
  int unsigned last_blk [ORDERS];
  logic [31:0] base_addr;

  bpa_pkg::rsp_t pending_rsp[$];
  int unsigned live_page[$];
  int unsigned live_ord[$];
  int errors = 0;
  int cycles = 0;
  bit start_hi = 0;
  int burst_left = 0;
  bit gaps_on = 1;

  function automatic void link_tail(int unsigned b, int unsigned k);
    int unsigned t;
    t = last_blk[k];
    nxt[b] = NONE;
    prv[b] = t;
    if (t < NONE) nxt[t] = b; else first_blk[k] = b;
    last_blk[k] = b;
    on_list[b] = 1;
    blk_ord[b] = k;
  endfunction

  function automatic void link_head(int unsigned b, int unsigned k);
    int unsigned h;
    h = first_blk[k];
    prv[b] = NONE;
    nxt[b] = h;
    if (h < NONE) prv[h] = b; else last_blk[k] = b;
    first_blk[k] = b;
    on_list[b] = 1;
    blk_ord[b] = k;
  endfunction

  function automatic void unlink(int unsigned b, int unsigned k);
    int unsigned p, n;
    p = prv[b];
    n = nxt[b];
    if (p < NONE) nxt[p] = n; else first_blk[k] = n;
    if (n < NONE) prv[n] = p; else last_blk[k] = p;
    nxt[b] = NONE;
    prv[b] = NONE;
    on_list[b] = 0;
  endfunction

  function automatic void reset_heap();
    int unsigned full;
    full = PAGES & ~((1 << TOP) - 1);
    base_addr = '0;
    for (int k = 0; k < ORDERS; k++) begin
      first_blk[k] = NONE;
      last_blk[k] = NONE;
    end
    for (int i = 0; i < PAGES; i++) begin
      nxt[i] = NONE; prv[i] = NONE; blk_ord[i] = 0; on_list[i] = 0; in_use[i] = 0;
    end
    for (int i = 0; i < full; i += (1 << TOP)) link_tail(i, TOP);
    for (int i = full; i < PAGES; i++) link_tail(i, 0);
  endfunction

  function automatic bpa_pkg::rsp_t heap_response(bpa_pkg::req_t r);
    bpa_pkg::rsp_t o;
    int unsigned j, b, k, sz, bud;
    logic [31:0] off;
    o.status = bpa_pkg::ST_BAD;
    o.block_address = '0;
    if (r.order >= ORDERS) return o;
    if (r.kind == bpa_pkg::KIND_ALLOC) begin
      j = r.order;
      while (j < ORDERS && first_blk[j] >= NONE) j++;
      if (j >= ORDERS) begin
        o.status = bpa_pkg::ST_NO_FREE;
        return o;
      end
      b = first_blk[j];
      unlink(b, j);
      for (k = j; k > r.order; k--) begin
        link_tail(b, k - 1);
        b += 1 << (k - 1);
      end
      in_use[b] = 1;
      blk_ord[b] = r.order;
      o.status = bpa_pkg::ST_OK;
      o.block_address = base_addr + (32'(b) << bpa_pkg::PG_SHIFT);
      live_page.push_back(b);
      live_ord.push_back(r.order);
    end else begin
      off = r.address - base_addr;
      sz = 1 << r.order;
      b = off >> bpa_pkg::PG_SHIFT;
      if (off[bpa_pkg::PG_SHIFT-1:0] != 0) return o;
      if (b >= PAGES || (b & (sz - 1)) != 0 || b + sz > PAGES) return o;
      if (!in_use[b]) begin
        o.status = bpa_pkg::ST_NOT_BSY;
        return o;
      end
      if (blk_ord[b] != r.order) return o;
      in_use[b] = 0;
      foreach (live_page[i]) if (live_page[i] == b) begin
        live_page.delete(i);
        live_ord.delete(i);
        break;
      end
      k = r.order;
      while (k < TOP) begin
        sz = 1 << k;
        bud = b ^ sz;
        if (bud + sz > PAGES) break;
        if (!on_list[bud] || in_use[bud] || blk_ord[bud] != k) break;
        unlink(bud, k);
        if (bud < b) b = bud;
        k++;
      end
      link_head(b, k);
      o.status = bpa_pkg::ST_OK;
    end
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    bpa_pkg::rsp_t want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result transaction: status %0d", rsp.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.block_address !== want.block_address) begin
          $error("block_address: expected %h, got %h", want.block_address,
                 rsp.block_address);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("buddy_page_allocator_top regression: fail");
      $finish;
    end
  end

  task automatic send_req(input logic kind, input logic [3:0] ord, input logic [31:0] addr);
    bpa_pkg::req_t r;
    r.kind = kind;
    r.order = ord;
    r.address = addr;
    start <= 1'b1;
    start_hi = 1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(heap_response(r));
    if (gaps_on) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        start_hi = 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic quiesce();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 0;
    end
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] v);
    quiesce();
    heap_base_we <= 1'b1;
    heap_base <= v;
    @(posedge clk);
    heap_base_we <= 1'b0;
    base_addr = v;
  endtask

  function automatic logic [31:0] page_addr(int unsigned p);
    return base_addr + (32'(p) << bpa_pkg::PG_SHIFT);
  endfunction

  task automatic free_all();
    while (live_page.size() != 0)
      send_req(bpa_pkg::KIND_FREE, live_ord[0], page_addr(live_page[0]));
  endtask

  task automatic test_directed();
    int unsigned p;
    send_req(bpa_pkg::KIND_ALLOC, 4'd0, $urandom);
    send_req(bpa_pkg::KIND_ALLOC, 4'd8, '0);
    send_req(bpa_pkg::KIND_ALLOC, 4'd9, '0);
    send_req(bpa_pkg::KIND_ALLOC, 4'd15, '1);
    send_req(bpa_pkg::KIND_FREE, 4'd15, '0);
    p = live_page[0];
    send_req(bpa_pkg::KIND_FREE, 4'd0, page_addr(p) + 32'd1);
    send_req(bpa_pkg::KIND_FREE, 4'd0, page_addr(p));
    send_req(bpa_pkg::KIND_FREE, 4'd0, page_addr(p));
    send_req(bpa_pkg::KIND_FREE, 4'd7, page_addr(live_page[0]));
    send_req(bpa_pkg::KIND_FREE, 4'd1, page_addr(1));
    send_req(bpa_pkg::KIND_FREE, 4'd0, page_addr(PAGES));
    send_req(bpa_pkg::KIND_FREE, 4'd0, 32'hFFFF_F000);
    send_req(bpa_pkg::KIND_ALLOC, 4'd3, '0);
    free_all();
  endtask

  task automatic test_exhaustion();
    free_all();
    repeat (PAGES / (1 << TOP) + 1) send_req(bpa_pkg::KIND_ALLOC, 4'd8, '0);
    send_req(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    free_all();
  endtask

  task automatic test_base_extremes();
    write_base(32'hFFFF_F000);
    send_req(bpa_pkg::KIND_ALLOC, 4'd1, '0);
    send_req(bpa_pkg::KIND_FREE, 4'd0, 32'h0000_0000);
    send_req(bpa_pkg::KIND_FREE, 4'd0, 32'hFFFF_E000);
    free_all();
    write_base(32'hFFFF_FFFF);
    send_req(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    free_all();
    write_base(32'h8000_0000);
    send_req(bpa_pkg::KIND_ALLOC, 4'd2, '0);
    send_req(bpa_pkg::KIND_FREE, 4'd2, 32'h7FFF_F000);
    free_all();
  endtask

  task automatic random_phase(input int count);
    int unsigned sel, i;
    logic [3:0] ord;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 48 || live_page.size() == 0) begin
        ord = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
            : ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 8))
            : 4'($urandom_range(0, 3));
        send_req(bpa_pkg::KIND_ALLOC, ord, $urandom);
      end else if (sel < 88) begin
        i = $urandom_range(0, live_page.size() - 1);
        send_req(bpa_pkg::KIND_FREE, live_ord[i], page_addr(live_page[i]));
      end else if (sel < 94) begin
        send_req(bpa_pkg::KIND_FREE, 4'($urandom), $urandom);
      end else begin
        send_req(bpa_pkg::KIND_FREE, 4'($urandom_range(0, 8)),
                 page_addr($urandom_range(0, PAGES - 1)));
      end
    end
  endtask

  task automatic test_random();
    gaps_on = 1;
    random_phase(ITEMS * 7 / 25);
    write_base({20'($urandom_range(0, 32'hFFFFF)), 12'h000});
    gaps_on = 0;
    random_phase(ITEMS * 4 / 25);
    gaps_on = 1;
    write_base($urandom);
    random_phase(ITEMS / 5);
    write_base(32'h0000_0000);
    random_phase(ITEMS / 5);
    free_all();
  endtask

  initial begin
    reset_heap();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_exhaustion();
    test_base_extremes();
    test_random();
    quiesce();
    repeat (100) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d result transactions never arrived", pending_rsp.size());
      errors++;
    end
    if (errors == 0) begin
      $display("buddy_page_allocator_top regression: pass");
    end else begin
      $display("buddy_page_allocator_top regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== buddy_page_allocator_top.f =====
src/bpa_pkg.sv
src/bpa_ctrl.sv
src/bpa_datapath.sv
src/buddy_page_allocator_top.sv
tb/sv/buddy_page_allocator_top_tb.sv
